### sv/dcbc_pkg.sv
// ----------------------------------------------------------------------------
// dcbc_pkg
// Shared types, constants and CRC helper functions for the dual CRC-16
// block checker.
// ----------------------------------------------------------------------------
package dcbc_pkg;

   localparam int unsigned CRC_WIDTH  = 16;
   localparam int unsigned BYTE_WIDTH = 8;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 16'h8005;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT = 16'h0000;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  last;
      logic [CRC_WIDTH-1:0]  ref_crc;
   } req_payload_type;

   typedef struct packed {
      logic                 match;
      logic [CRC_WIDTH-1:0] crc_plain;
      logic [CRC_WIDTH-1:0] crc_reflected;
   } rsp_payload_type;

   // control from the top level to the CRC core
   typedef struct packed {
      logic advance;   // item leaves the input register this cycle
      logic clear;     // item closes the block: restart both remainders
   } crc_ctrl_type;

   // Shift one byte into the remainder, MSB first.
   function automatic logic [CRC_WIDTH-1:0] crc_byte(
      input logic [CRC_WIDTH-1:0]  rem,
      input logic [BYTE_WIDTH-1:0] data
   );
      logic [CRC_WIDTH-1:0] r;
      logic                 fb;
      r = rem;
      for (int i = BYTE_WIDTH - 1; i >= 0; i--) begin
         fb = r[CRC_WIDTH-1] ^ data[i];
         r  = {r[CRC_WIDTH-2:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] reverse8(input logic [BYTE_WIDTH-1:0] v);
      logic [BYTE_WIDTH-1:0] r;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         r[i] = v[BYTE_WIDTH-1-i];
      end
      return r;
   endfunction

   function automatic logic [CRC_WIDTH-1:0] reverse16(input logic [CRC_WIDTH-1:0] v);
      logic [CRC_WIDTH-1:0] r;
      for (int i = 0; i < CRC_WIDTH; i++) begin
         r[i] = v[CRC_WIDTH-1-i];
      end
      return r;
   endfunction

endpackage

### sv/dcbc_crc_core.sv
// ----------------------------------------------------------------------------
// dcbc_crc_core
// Holds the plain and reflected CRC-16 remainders and gives their values
// after the current byte, already in output form.
// ----------------------------------------------------------------------------
module dcbc_crc_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dcbc_pkg::crc_ctrl_type               ctrl,
   input  logic [dcbc_pkg::BYTE_WIDTH-1:0]      data_byte,
   output logic [dcbc_pkg::CRC_WIDTH-1:0]       crc_plain,
   output logic [dcbc_pkg::CRC_WIDTH-1:0]       crc_reflected
);
   import dcbc_pkg::*;

   logic [CRC_WIDTH-1:0] plain_rem_ff;
   logic [CRC_WIDTH-1:0] plain_rem_in;
   logic [CRC_WIDTH-1:0] refl_rem_ff;
   logic [CRC_WIDTH-1:0] refl_rem_in;
   logic [CRC_WIDTH-1:0] plain_upd;
   logic [CRC_WIDTH-1:0] refl_upd;

   // fold the byte into both remainders; the reflected one takes it LSB first
   always_comb begin
      plain_upd = crc_byte(plain_rem_ff, data_byte);
      refl_upd  = crc_byte(refl_rem_ff, reverse8(data_byte));
   end

   assign crc_plain     = plain_upd;
   assign crc_reflected = reverse16(refl_upd);

   // advance on each item, restart after the last one
   always_comb begin
      plain_rem_in = plain_rem_ff;
      refl_rem_in  = refl_rem_ff;
      if (ctrl.advance) begin
         if (ctrl.clear) begin
            plain_rem_in = CRC_INIT;
            refl_rem_in  = CRC_INIT;
         end else begin
            plain_rem_in = plain_upd;
            refl_rem_in  = refl_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_rem_ff <= CRC_INIT;
         refl_rem_ff  <= CRC_INIT;
      end else begin
         plain_rem_ff <= plain_rem_in;
         refl_rem_ff  <= refl_rem_in;
      end
   end

endmodule

### sv/dual_crc16_block_checker.sv
// ----------------------------------------------------------------------------
// dual_crc16_block_checker
// Byte-serial CRC-16/BUYPASS and CRC-16/ARC check of a block against a
// reference CRC carried with the last byte.
// ----------------------------------------------------------------------------
// Path: the accepted item is registered in the input register, then the
//   byte-parallel CRC update loads the result register from it.
// Throughput: one byte per cycle, set by the XOR update; a last
//   item waits in the input register while a stalled result is still held.
// Reset: synchronous; clears both pipeline valids and both remainders to zero.
module dual_crc16_block_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dcbc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dcbc_pkg::rsp_payload_type rsp_payload
);
   import dcbc_pkg::*;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            s1_adv;
   logic            req_take;
   crc_ctrl_type    crc_ctrl;
   logic [CRC_WIDTH-1:0] crc_plain;
   logic [CRC_WIDTH-1:0] crc_reflected;

   // advance unless a last item waits on a blocked result register
   assign s1_adv    = s1_valid_ff &&
                      (!s1_ff.last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign crc_ctrl.advance = s1_adv;
   assign crc_ctrl.clear   = s1_ff.last;

   dcbc_crc_core u_crc_core (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (crc_ctrl),
      .data_byte     (s1_ff.data_byte),
      .crc_plain     (crc_plain),
      .crc_reflected (crc_reflected)
   );

   // build the result item
   always_comb begin
      rsp_in.crc_plain     = crc_plain;
      rsp_in.crc_reflected = crc_reflected;
      rsp_in.match         = (crc_plain == s1_ff.ref_crc) ||
                             (crc_reflected == s1_ff.ref_crc);
   end

   // valid bits of both registers
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv && s1_ff.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture payloads; hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_payload;
      end
      if (s1_adv && s1_ff.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("result dropped while stalled");

   // input side stalls only with an item in the input register
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_ff.last && rsp_valid_ff)
      else $error("input stalled without a blocked last item");

   // a last item moving on produces a result
   a_last_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_ff.last |=> rsp_valid_ff)
      else $error("last item gave no result");

   // a taken result with nothing behind it leaves the register empty
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !(s1_adv && s1_ff.last) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule
